FILE: rtl/pec_pkg.sv
// Shared constants, codes and types of the periodic event countdown block.
package pec_pkg;

    localparam int MAX_STARTS_DEF = 16;
    localparam int MAX_COPIES = 16;
    localparam logic [19:0] DAY_SECONDS = 20'd86400;

    // Schedule modes (codes 2 and 3 both mean repeat)
    localparam logic [1:0] MODE_DAY = 2'd0;
    localparam logic [1:0] MODE_CYCLE = 2'd1;

    // Input kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_CYCLE_LEN   = 3'd1,
        REG_PHASE       = 3'd2,
        REG_ACTIVE_LEN  = 3'd3,
        REG_COPIES      = 3'd4,
        REG_START_COUNT = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_PH,
        S_STR,
        S_LAUNCH,
        S_SCAN,
        S_DONE
    } state_t;

    // Static scan setup, held for the whole query
    typedef struct packed {
        logic        rep;
        logic [19:0] cyc;
        logic [19:0] act;
        logic [19:0] stride;
    } scan_cfg_t;

    // Token that walks down the cell chain
    typedef struct packed {
        logic        vld;
        logic        done;
        logic        live;
        logic [19:0] pos;
        logic [19:0] st;
        logic [20:0] best;
        logic [19:0] t0;
        logic [21:0] us;
        logic [20:0] ue;
    } tok_t;

endpackage

FILE: rtl/pec_divider.sv
// Radix-2 restoring divider: 63-bit or 20-bit dividend by a 20-bit divisor.
module pec_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        long_op,
    input  logic [62:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [19:0] quotient,
    output logic [19:0] remainder
);

    logic [62:0] a_reg, a_next;
    logic [19:0] rem_reg, rem_next;
    logic [19:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [20:0] trial;

    // One quotient bit per cycle
    always_comb begin
        a_next = a_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        trial = {rem_reg, a_reg[62]};
        if (start) begin
            a_next = long_op ? dividend : {dividend[19:0], 43'b0};
            rem_next = '0;
            q_next = '0;
            cnt_next = long_op ? 6'd63 : 6'd20;
        end else if (cnt_reg != 6'd0) begin
            a_next = {a_reg[61:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = 20'(trial - {1'b0, divisor});
                q_next = {q_reg[18:0], 1'b1};
            end else begin
                rem_next = trial[19:0];
                q_next = {q_reg[18:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/pec_cell.sv
// One chain cell: holds one start entry, tests one start or copy, passes the token on.
module pec_cell #(
    parameter int IDX = 0,
    parameter int MAX_STARTS = pec_pkg::MAX_STARTS_DEF,
    parameter int LW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [3:0]          wr_slot,
    input  logic [19:0]         wr_value,
    input  pec_pkg::scan_cfg_t  cfg,
    input  logic [LW-1:0]       lim,
    input  pec_pkg::tok_t       tok_in,
    output pec_pkg::tok_t       tok_out
);

    localparam bit WRITABLE = (IDX < MAX_STARTS) && (IDX < 16);
    localparam logic [3:0] SLOT_ID = 4'(IDX % 16);

    logic [19:0]   entry_reg;
    pec_pkg::tok_t tok_reg, tok_next;
    logic          active;
    logic [20:0]   st_sum, diff, wrap_gap, b_end;
    logic [19:0]   st_new, age;

    // Table entry write
    always_ff @(posedge aclk) begin
        if (WRITABLE && wr_en && (wr_slot == SLOT_ID)) begin
            entry_reg <= wr_value;
        end
    end

    // Copy start, its age and the test of this cell
    always_comb begin
        active = (LW'(IDX) < lim);
        st_sum = {1'b0, tok_in.st} + {1'b0, cfg.stride};
        if (IDX == 0) begin
            st_new = tok_in.st;
        end else if (st_sum >= {1'b0, cfg.cyc}) begin
            st_new = 20'(st_sum - {1'b0, cfg.cyc});
        end else begin
            st_new = st_sum[19:0];
        end
        diff = {1'b0, tok_in.pos} - {1'b0, st_new};
        age = diff[20] ? 20'(diff + {1'b0, cfg.cyc}) : diff[19:0];
        wrap_gap = {1'b0, cfg.cyc} - {1'b0, age};
        b_end = {1'b0, entry_reg} + {1'b0, cfg.act};

        tok_next = tok_in;
        tok_next.st = st_new;
        if (IDX == 0) begin
            tok_next.t0 = entry_reg;
        end
        if (tok_in.vld && !tok_in.done && active) begin
            if (cfg.rep) begin
                if (age < cfg.act) begin
                    tok_next.done = 1'b1;
                    tok_next.live = 1'b1;
                    tok_next.us = '0;
                    tok_next.ue = {1'b0, cfg.act} - {1'b0, age};
                end else if (wrap_gap < tok_in.best) begin
                    tok_next.best = wrap_gap;
                end
            end else begin
                if (tok_in.pos < entry_reg) begin
                    tok_next.done = 1'b1;
                    tok_next.live = 1'b0;
                    tok_next.us = {2'b0, entry_reg} - {2'b0, tok_in.pos};
                    tok_next.ue = '1;
                end else if ({1'b0, tok_in.pos} < b_end) begin
                    tok_next.done = 1'b1;
                    tok_next.live = 1'b1;
                    tok_next.us = '0;
                    tok_next.ue = b_end - {1'b0, tok_in.pos};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/periodic_event_countdown_top.sv
// Top level of the periodic event countdown block.
// A load transaction (tuser 1) writes one start-table entry in the cycle it is
// accepted and gives no result. A query transaction (tuser 0) gives one result:
// the time is first reduced by a radix-2 divider, one bit per cycle; repeat mode
// then reduces the phase and divides the cycle by the copy count on the same
// divider; then a token walks the chain of max(MAX_STARTS, 16) cells, one cell
// per cycle. A query with no schedule skips the divider and the chain. Input is
// taken one item at a time; the result waits in an output register. A cycle,
// active or start-count setting of zero that leaves no schedule returns
// until_start and until_end of -1.
module periodic_event_countdown_top #(
    parameter int MAX_STARTS = pec_pkg::MAX_STARTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // now[62:0], slot[66:63], start_value[86:67]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // live[0], until_start[22:1], until_end[43:23]
);

    localparam int NCELL = (MAX_STARTS > pec_pkg::MAX_COPIES) ? MAX_STARTS
                                                              : pec_pkg::MAX_COPIES;
    localparam int LW = $clog2(NCELL + 1);

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [19:0] cycle_len_reg, phase_reg, active_len_reg;
    logic [4:0]  copies_reg, start_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd2;
            cycle_len_reg <= '0;
            phase_reg <= '0;
            active_len_reg <= '0;
            copies_reg <= 5'd1;
            start_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pec_pkg::REG_MODE:        mode_reg <= cfg_wdata[1:0];
                pec_pkg::REG_CYCLE_LEN:   cycle_len_reg <= cfg_wdata;
                pec_pkg::REG_PHASE:       phase_reg <= cfg_wdata;
                pec_pkg::REG_ACTIVE_LEN:  active_len_reg <= cfg_wdata;
                pec_pkg::REG_COPIES:      copies_reg <= cfg_wdata[4:0];
                pec_pkg::REG_START_COUNT: start_count_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Derived schedule setup
    logic          rep;
    logic [19:0]   cyc_eff;
    logic [4:0]    k_eff;
    logic [LW-1:0] n_eff, lim;
    logic          no_sched;

    always_comb begin
        rep = mode_reg[1];
        cyc_eff = (mode_reg == pec_pkg::MODE_DAY) ? pec_pkg::DAY_SECONDS : cycle_len_reg;
        if (copies_reg == 5'd0) begin
            k_eff = 5'd1;
        end else if (copies_reg > 5'(pec_pkg::MAX_COPIES)) begin
            k_eff = 5'(pec_pkg::MAX_COPIES);
        end else begin
            k_eff = copies_reg;
        end
        n_eff = (LW'(start_count_reg) > LW'(MAX_STARTS)) ? LW'(MAX_STARTS)
                                                        : LW'(start_count_reg);
        lim = rep ? LW'(k_eff) : n_eff;
        no_sched = rep ? (cycle_len_reg == '0 || active_len_reg == '0)
                       : (n_eff == '0 || active_len_reg == '0 || cyc_eff == '0);
    end

    // Divider
    logic        div_start, div_long, div_done;
    logic [62:0] div_a;
    logic [19:0] div_d, div_q, div_r;

    pec_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .long_op   (div_long),
        .dividend  (div_a),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Cell chain
    pec_pkg::tok_t     tok [0:NCELL];
    pec_pkg::tok_t     tok_head;
    pec_pkg::scan_cfg_t scfg;
    pec_pkg::tok_t     fin;
    logic              load_wr;

    pec_pkg::state_t state_reg, state_next;
    logic [19:0] pos_reg, pos_next, ph_reg, ph_next, stride_reg, stride_next;
    logic        r_live_reg, r_live_next;
    logic [21:0] r_us_reg, r_us_next;
    logic [20:0] r_ue_reg, r_ue_next;
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        s_acc;

    assign load_wr = s_acc && (s_tuser == pec_pkg::KIND_LOAD);
    assign scfg = '{rep: rep, cyc: cyc_eff, act: active_len_reg, stride: stride_reg};
    assign tok[0] = tok_head;
    assign fin = tok[NCELL];

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            pec_cell #(.IDX(gi), .MAX_STARTS(MAX_STARTS), .LW(LW)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .wr_en    (load_wr),
                .wr_slot  (s_tdata[66:63]),
                .wr_value (s_tdata[86:67]),
                .cfg      (scfg),
                .lim      (lim),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    assign s_tready = (state_reg == pec_pkg::S_IDLE);
    assign s_acc = s_tvalid && s_tready;

    // Sequencer: next state, divider control, token launch, result capture
    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        ph_next = ph_reg;
        stride_next = stride_reg;
        r_live_next = r_live_reg;
        r_us_next = r_us_reg;
        r_ue_next = r_ue_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        div_start = 1'b0;
        div_long = 1'b0;
        div_a = s_tdata[62:0];
        div_d = cyc_eff;
        tok_head = '{vld: 1'b0, done: 1'b0, live: 1'b0, pos: pos_reg, st: ph_reg,
                     best: {1'b0, cyc_eff}, t0: '0, us: '0, ue: '0};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pec_pkg::S_IDLE: begin
                if (s_acc && s_tuser == pec_pkg::KIND_QUERY) begin
                    if (no_sched) begin
                        r_live_next = 1'b0;
                        r_us_next = '1;
                        r_ue_next = '1;
                        state_next = pec_pkg::S_DONE;
                    end else begin
                        div_start = 1'b1;
                        div_long = 1'b1;
                        state_next = pec_pkg::S_POS;
                    end
                end
            end
            pec_pkg::S_POS: begin
                if (div_done) begin
                    pos_next = div_r;
                    ph_next = '0;
                    if (rep) begin
                        div_start = 1'b1;
                        div_a = {43'b0, phase_reg};
                        state_next = pec_pkg::S_PH;
                    end else begin
                        state_next = pec_pkg::S_LAUNCH;
                    end
                end
            end
            pec_pkg::S_PH: begin
                if (div_done) begin
                    ph_next = div_r;
                    div_start = 1'b1;
                    div_a = {43'b0, cycle_len_reg};
                    div_d = {15'b0, k_eff};
                    state_next = pec_pkg::S_STR;
                end
            end
            pec_pkg::S_STR: begin
                div_d = {15'b0, k_eff};
                if (div_done) begin
                    stride_next = div_q;
                    state_next = pec_pkg::S_LAUNCH;
                end
            end
            pec_pkg::S_LAUNCH: begin
                tok_head.vld = 1'b1;
                state_next = pec_pkg::S_SCAN;
            end
            pec_pkg::S_SCAN: begin
                if (fin.vld) begin
                    if (fin.done) begin
                        r_live_next = fin.live;
                        r_us_next = fin.us;
                        r_ue_next = fin.ue;
                    end else begin
                        r_live_next = 1'b0;
                        r_ue_next = '1;
                        r_us_next = rep ? {1'b0, fin.best}
                                        : {2'b0, cyc_eff} - {2'b0, fin.pos}
                                          + {2'b0, fin.t0};
                    end
                    state_next = pec_pkg::S_DONE;
                end
            end
            pec_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = {4'b0, r_ue_reg, r_us_reg, r_live_reg};
                    state_next = pec_pkg::S_IDLE;
                end
            end
            default: state_next = pec_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pec_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg <= pos_next;
        ph_reg <= ph_next;
        stride_reg <= stride_next;
        r_live_reg <= r_live_next;
        r_us_reg <= r_us_next;
        r_ue_reg <= r_ue_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule

FILE: rtl/pec_checker.sv
// Port-level checks of the periodic event countdown block, bound to its top level.
module pec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Live result: zero to start, finite window end
    a_live_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[22:1] == 22'd0 && m_tdata[43:23] != 21'h1FFFFF)
        else $error("live result with bad fields");

    // Not live: window end reads -1
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[43:23] == 21'h1FFFFF)
        else $error("inactive result with a window end");

    // A load transaction never raises a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !$rose(m_tvalid))
        else $error("result after a table load");

endmodule

bind periodic_event_countdown_top pec_checker u_pec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
